// ----- sv/slce_pkg.sv -----
// Shared types and constants for the serial line coding encoder.
package slce_pkg;

    // Fixed-rate shortcuts
    localparam logic [31:0] RATE_FIXED_HI  = 32'd921600;
    localparam logic [31:0] RATE_FIXED_LO  = 32'd307200;
    localparam logic [7:0]  FAC_FIXED_HI   = 8'hF3;
    localparam logic [7:0]  FAC_FIXED_LO   = 8'hD9;
    localparam logic [2:0]  PRE_FIXED      = 3'd7;

    // Prescaler of each band
    localparam logic [2:0]  PRE_BAND3      = 3'd3;
    localparam logic [2:0]  PRE_BAND2      = 3'd2;
    localparam logic [2:0]  PRE_BAND1      = 3'd1;
    localparam logic [2:0]  PRE_BAND0      = 3'd0;

    // Prescaler band clocks
    localparam int unsigned CLK_W          = 23;
    localparam int unsigned BAND3_HZ       = 6000000;
    localparam int unsigned BAND2_HZ       = 750000;
    localparam int unsigned BAND1_HZ       = 93750;
    localparam int unsigned BAND0_HZ       = 11719;
    localparam logic [CLK_W-1:0] CLK_BAND3 = CLK_W'(BAND3_HZ);
    localparam logic [CLK_W-1:0] CLK_BAND2 = CLK_W'(BAND2_HZ);
    localparam logic [CLK_W-1:0] CLK_BAND1 = CLK_W'(BAND1_HZ);
    localparam logic [CLK_W-1:0] CLK_BAND0 = CLK_W'(BAND0_HZ);

    // A rate above the limit keeps the factor under 255 in that band
    localparam logic [31:0] LIMIT_BAND3    = 32'(BAND3_HZ / 255);
    localparam logic [31:0] LIMIT_BAND2    = 32'(BAND2_HZ / 255);
    localparam logic [31:0] LIMIT_BAND1    = 32'(BAND1_HZ / 255);

    // Quotient of band clock by rate never exceeds 14 bits
    localparam int unsigned FQ_W           = 14;

    localparam logic [7:0]  BAUD_LOW_FLAG  = 8'h80;

    // Line control bits
    localparam logic [7:0]  LCR_RX_EN      = 8'h80;
    localparam logic [7:0]  LCR_TX_EN      = 8'h40;
    localparam logic [7:0]  LCR_MARKSPACE  = 8'h20;
    localparam logic [7:0]  LCR_EVEN       = 8'h10;
    localparam logic [7:0]  LCR_PAR_EN     = 8'h08;
    localparam logic [7:0]  LCR_STOP2      = 8'h04;

    // Request codes
    localparam logic [7:0]  DATA_BITS_MIN  = 8'd5;
    localparam logic [7:0]  DATA_BITS_MAX  = 8'd8;
    localparam logic [7:0]  PAR_NONE       = 8'd0;
    localparam logic [7:0]  PAR_ODD        = 8'd1;
    localparam logic [7:0]  PAR_EVEN       = 8'd2;
    localparam logic [7:0]  PAR_MARK       = 8'd3;
    localparam logic [7:0]  PAR_SPACE      = 8'd4;
    localparam logic [7:0]  STOP_ONE       = 8'd0;
    localparam logic [7:0]  STOP_TWO       = 8'd2;

    // Status codes
    localparam logic [2:0]  ST_OK          = 3'd0;
    localparam logic [2:0]  ST_BAD_BAUD    = 3'd1;
    localparam logic [2:0]  ST_BAD_DATA    = 3'd2;
    localparam logic [2:0]  ST_BAD_PARITY  = 3'd3;
    localparam logic [2:0]  ST_BAD_STOP    = 3'd4;

    // Sideband through the factor divider
    typedef struct packed {
        logic              zero;
        logic              fixed;
        logic [7:0]        fixed_fac;
        logic [2:0]        pre;
        logic [31:0]       rate;
        logic [CLK_W-1:0]  clk_hz;
        logic              lcr_write;
        logic [7:0]        lcr_byte;
        logic [2:0]        lcr_status;
    } side1_t;

    // Sideband through the rounding divider for factor f
    typedef struct packed {
        side1_t            s;
        logic [7:0]        fac;
    } side2_t;

endpackage

// ----- sv/serial_line_coding_encoder_unit.sv -----
// Top level of the serial line coding encoder: line coding request to UART register words.
// Turns one line coding request into a baud word, a line control byte and a status code,
// one result beat per request beat. It runs through an input register, a 15-stage
// divider for band clock / rate, a pair of 24-stage dividers that give the two candidate
// achieved rates for rounding, then the output register. A new beat is taken every cycle;
// in_ready is low only while the output register holds a beat that out_ready refuses, and
// then the whole pipeline holds. Fixed rates and zero rates ride the same pipeline.
module serial_line_coding_encoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  line_rate,
    input  logic [7:0]   data_bits,
    input  logic [7:0]   parity_type,
    input  logic [7:0]   stop_format,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         baud_write,
    output logic [15:0]  baud_word,
    output logic         lcr_write,
    output logic [7:0]   lcr_byte,
    output logic [2:0]   status
);

    localparam int unsigned CW = slce_pkg::CLK_W;
    localparam int unsigned QF = slce_pkg::FQ_W;

    logic adv;

    // Input register
    logic         s1_valid_reg;
    logic [31:0]  s1_rate_reg;
    logic [7:0]   s1_db_reg;
    logic [7:0]   s1_par_reg;
    logic [7:0]   s1_stp_reg;

    // Output register
    logic         out_valid_reg;
    logic         bw_reg;
    logic [15:0]  bword_reg;
    logic         lw_reg;
    logic [7:0]   lcr_reg;
    logic [2:0]   st_reg;

    logic         bw_next;
    logic [15:0]  bword_next;
    logic         lw_next;
    logic [7:0]   lcr_next;
    logic [2:0]   st_next;

    slce_pkg::side1_t side1;
    slce_pkg::side1_t d1_side;
    slce_pkg::side2_t side2;
    slce_pkg::side2_t d2_side;

    logic           d1_valid;
    logic [QF-1:0]  d1_quo;
    logic           d2_valid;
    logic [CW-1:0]  q_lo;
    logic [CW-1:0]  q_hi;
    logic           bad_fac;
    logic           d3_bad;
    logic [7:0]     fac;
    logic [7:0]     db_off;
    logic [7:0]     lcr_v;

    // Whole pipeline moves unless the output beat is stalled
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rate_reg <= line_rate;
            s1_db_reg   <= data_bits;
            s1_par_reg  <= parity_type;
            s1_stp_reg  <= stop_format;
        end
    end

    // Band select, fixed rates and line control byte
    always_comb
    begin
        side1.zero  = (s1_rate_reg == 32'd0);
        side1.fixed = (s1_rate_reg == slce_pkg::RATE_FIXED_HI)
                   || (s1_rate_reg == slce_pkg::RATE_FIXED_LO);
        side1.fixed_fac = (s1_rate_reg == slce_pkg::RATE_FIXED_HI)
                        ? slce_pkg::FAC_FIXED_HI : slce_pkg::FAC_FIXED_LO;
        side1.rate  = s1_rate_reg;
        if (s1_rate_reg > slce_pkg::LIMIT_BAND3)
        begin
            side1.pre    = slce_pkg::PRE_BAND3;
            side1.clk_hz = slce_pkg::CLK_BAND3;
        end
        else if (s1_rate_reg > slce_pkg::LIMIT_BAND2)
        begin
            side1.pre    = slce_pkg::PRE_BAND2;
            side1.clk_hz = slce_pkg::CLK_BAND2;
        end
        else if (s1_rate_reg > slce_pkg::LIMIT_BAND1)
        begin
            side1.pre    = slce_pkg::PRE_BAND1;
            side1.clk_hz = slce_pkg::CLK_BAND1;
        end
        else
        begin
            side1.pre    = slce_pkg::PRE_BAND0;
            side1.clk_hz = slce_pkg::CLK_BAND0;
        end
        if (side1.fixed)
        begin
            side1.pre = slce_pkg::PRE_FIXED;
        end

        db_off           = s1_db_reg - slce_pkg::DATA_BITS_MIN;
        lcr_v            = slce_pkg::LCR_RX_EN | slce_pkg::LCR_TX_EN;
        side1.lcr_status = slce_pkg::ST_OK;
        side1.lcr_write  = 1'b0;
        side1.lcr_byte   = 8'd0;
        if (s1_db_reg != 8'd0)
        begin
            if (s1_db_reg inside {[slce_pkg::DATA_BITS_MIN:slce_pkg::DATA_BITS_MAX]})
            begin
                lcr_v = lcr_v | {6'd0, db_off[1:0]};
            end
            else
            begin
                side1.lcr_status = slce_pkg::ST_BAD_DATA;
            end
            if (side1.lcr_status == slce_pkg::ST_OK)
            begin
                case (s1_par_reg)
                    slce_pkg::PAR_NONE:  ;
                    slce_pkg::PAR_ODD:   lcr_v = lcr_v | slce_pkg::LCR_PAR_EN;
                    slce_pkg::PAR_EVEN:  lcr_v = lcr_v | slce_pkg::LCR_PAR_EN
                                               | slce_pkg::LCR_EVEN;
                    slce_pkg::PAR_MARK:  lcr_v = lcr_v | slce_pkg::LCR_PAR_EN
                                               | slce_pkg::LCR_MARKSPACE;
                    slce_pkg::PAR_SPACE: lcr_v = lcr_v | slce_pkg::LCR_PAR_EN
                                               | slce_pkg::LCR_MARKSPACE
                                               | slce_pkg::LCR_EVEN;
                    default:             side1.lcr_status = slce_pkg::ST_BAD_PARITY;
                endcase
            end
            if (side1.lcr_status == slce_pkg::ST_OK)
            begin
                if (s1_stp_reg == slce_pkg::STOP_TWO)
                begin
                    lcr_v = lcr_v | slce_pkg::LCR_STOP2;
                end
                else if (s1_stp_reg != slce_pkg::STOP_ONE)
                begin
                    side1.lcr_status = slce_pkg::ST_BAD_STOP;
                end
            end
            if (side1.lcr_status == slce_pkg::ST_OK)
            begin
                side1.lcr_write = 1'b1;
                side1.lcr_byte  = lcr_v;
            end
        end
    end

    // Factor: band clock / rate
    slce_div_pipe #(
        .NW  (CW),
        .DVW (32),
        .QW  (QF),
        .SW  ($bits(slce_pkg::side1_t))
    ) u_div_fac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .num       (side1.clk_hz),
        .den       (s1_rate_reg),
        .side      (side1),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .out_side  (d1_side)
    );

    // Truncate factor, reject the two unusable values
    assign fac      = d1_quo[7:0];
    assign bad_fac  = (fac == 8'd0) || (fac == 8'hFF);
    assign side2.s  = d1_side;
    assign side2.fac = fac;

    // Achieved rate at factor f
    slce_div_pipe #(
        .NW  (CW),
        .DVW (9),
        .QW  (CW),
        .SW  ($bits(slce_pkg::side2_t))
    ) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_valid),
        .num       (d1_side.clk_hz),
        .den       ({1'b0, fac}),
        .side      (side2),
        .out_valid (d2_valid),
        .quo       (q_lo),
        .out_side  (d2_side)
    );

    // Achieved rate at factor f+1
    slce_div_pipe #(
        .NW  (CW),
        .DVW (9),
        .QW  (CW),
        .SW  (1)
    ) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_valid),
        .num       (d1_side.clk_hz),
        .den       ({1'b0, fac} + 9'd1),
        .side      (bad_fac),
        .out_valid (),
        .quo       (q_hi),
        .out_side  (d3_bad)
    );

    // Round toward the nearer achieved rate, negate, assemble the beat
    logic [CW:0]   q_sum;
    logic          round_up;
    logic [7:0]    fac_r;
    logic [7:0]    fac_neg;
    logic [7:0]    word_lo;

    always_comb
    begin
        q_sum    = {1'b0, q_lo} + {1'b0, q_hi};
        round_up = {{(32 - CW){1'b0}}, q_sum} > {d2_side.s.rate, 1'b0};
        fac_r    = d2_side.fac + {7'd0, round_up};
        fac_neg  = 8'd0 - fac_r;
        word_lo  = slce_pkg::BAUD_LOW_FLAG | {5'd0, d2_side.s.pre};

        bw_next    = 1'b0;
        bword_next = 16'd0;
        lw_next    = d2_side.s.lcr_write;
        lcr_next   = d2_side.s.lcr_byte;
        st_next    = d2_side.s.lcr_status;
        if (!d2_side.s.zero)
        begin
            if (d2_side.s.fixed)
            begin
                bw_next    = 1'b1;
                bword_next = {d2_side.s.fixed_fac, word_lo};
            end
            else if (d3_bad)
            begin
                st_next  = slce_pkg::ST_BAD_BAUD;
                lw_next  = 1'b0;
                lcr_next = 8'd0;
            end
            else
            begin
                bw_next    = 1'b1;
                bword_next = {fac_neg, word_lo};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bw_reg    <= bw_next;
            bword_reg <= bword_next;
            lw_reg    <= lw_next;
            lcr_reg   <= lcr_next;
            st_reg    <= st_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign baud_write = bw_reg;
    assign baud_word  = bword_reg;
    assign lcr_write  = lw_reg;
    assign lcr_byte   = lcr_reg;
    assign status     = st_reg;

endmodule

// ----- sv/slce_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module slce_div_pipe #(
    parameter int unsigned NW  = 23,
    parameter int unsigned DVW = 32,
    parameter int unsigned QW  = 14,
    parameter int unsigned SW  = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [DVW-1:0]  den,
    input  logic [SW-1:0]   side,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic [SW-1:0]   out_side
);

    localparam int unsigned RQW = DVW + QW;

    logic                 valid_reg [0:QW];
    logic [RQW-1:0]       rq_reg    [0:QW];
    logic [DVW-1:0]       den_reg   [0:QW];
    logic [SW-1:0]        side_reg  [0:QW];
    logic [NW+DVW-1:0]    num_ext;

    // High dividend bits form the starting remainder (already below den)
    assign num_ext = {{DVW{1'b0}}, num};

    // Entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rq_reg[0]   <= {num_ext[QW +: DVW], num[QW-1:0]};
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
    end

    // One compare-subtract per stage
    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [DVW:0]    partial;
        logic [DVW:0]    diff;
        logic            ge;
        logic [RQW-1:0]  rq_next;

        always_comb
        begin
            partial = rq_reg[i][RQW-1:QW-1];
            diff    = partial - {1'b0, den_reg[i]};
            ge      = (partial >= {1'b0, den_reg[i]});
            if (ge)
            begin
                rq_next = {diff[DVW-1:0], rq_reg[i][QW-2:0], 1'b1};
            end
            else
            begin
                rq_next = {partial[DVW-1:0], rq_reg[i][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rq_reg[i+1]   <= rq_next;
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = rq_reg[QW][QW-1:0];
    assign out_side  = side_reg[QW];

endmodule
